### rtl/eoq_pkg.sv
`default_nettype none

package eoq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_BITS     = 32;
    localparam int FIELD_BITS   = 32;

    typedef enum logic [1:0] {
        CMD_PUSH       = 2'd0,
        CMD_POP_OLDEST = 2'd1,
        CMD_POP_EXPIRY = 2'd2,
        CMD_CLEAR      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_scan_ctl;

endpackage

`default_nettype wire

### rtl/eoq_ram.sv
`default_nettype none

module eoq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/eoq_scan.sv
`default_nettype none

module eoq_scan #(
    parameter int DEPTH = eoq_pkg::QUEUE_DEPTH,
    parameter int PAY_W = eoq_pkg::PAYLOAD_BITS
) (
    input  wire logic                         i_clk,
    input  wire eoq_pkg::t_scan_ctl           i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0]     i_idx,
    input  wire logic [eoq_pkg::KEY_BITS-1:0] i_key,
    input  wire logic [PAY_W-1:0]             i_pay,
    output logic      [$clog2(DEPTH)-1:0]     o_best_idx,
    output logic      [eoq_pkg::KEY_BITS-1:0] o_best_key,
    output logic      [PAY_W-1:0]             o_best_pay
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [IDX_W-1:0]             r_best_idx, n_best_idx;
    logic [eoq_pkg::KEY_BITS-1:0] r_best_key, n_best_key;
    logic [PAY_W-1:0]             r_best_pay, n_best_pay;

    // strict less-than: on equal keys the entry nearer the head stays
    always_comb begin
        n_best_idx = r_best_idx;
        n_best_key = r_best_key;
        n_best_pay = r_best_pay;
        if (i_ctl.load || (i_ctl.step && (i_key < r_best_key))) begin
            n_best_idx = i_idx;
            n_best_key = i_key;
            n_best_pay = i_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_idx <= n_best_idx;
        r_best_key <= n_best_key;
        r_best_pay <= n_best_pay;
    end

    assign o_best_idx = n_best_idx;
    assign o_best_key = n_best_key;
    assign o_best_pay = n_best_pay;

endmodule

`default_nettype wire

### rtl/expiry_ordered_queue_top.sv
`default_nettype none

// channel  | valid       | ready       | payload
// ---------+-------------+-------------+------------------------------------------
// request  | i_in_valid  | o_in_ready  | i_cmd, i_expiry_key, i_item_payload
// result   | o_out_valid | i_out_ready | o_ok, o_out_expiry, o_out_payload,
//          |             |             | o_now_empty
//
// Entries sit in one RAM, head at address 0, packed towards the tail.
// A pop reads entries one a cycle from the single read port (pop oldest reads only
// the head, pop by expiry reads all N), then moves the entries behind the removed
// one down by one a cycle.
// Reset empties the queue at once; the RAM itself is not cleared.
// A new request is taken while the last result still waits at the output.
module expiry_ordered_queue_top #(
    parameter int QUEUE_DEPTH  = eoq_pkg::QUEUE_DEPTH,
    parameter int PAYLOAD_BITS = eoq_pkg::PAYLOAD_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_cmd,
    input  wire logic [eoq_pkg::KEY_BITS-1:0]   i_expiry_key,
    input  wire logic [eoq_pkg::FIELD_BITS-1:0] i_item_payload,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_ok,
    output logic      [eoq_pkg::KEY_BITS-1:0]   o_out_expiry,
    output logic      [eoq_pkg::FIELD_BITS-1:0] o_out_payload,
    output logic                                o_now_empty
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W  = eoq_pkg::KEY_BITS;
    localparam int FLD_W  = eoq_pkg::FIELD_BITS;
    localparam int WORD_W = KEY_W + PAYLOAD_BITS;
    localparam int WIDE_W = 64;

    eoq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_oldest, n_oldest;

    logic                    r_res_ok, n_res_ok;
    logic [KEY_W-1:0]        r_res_key, n_res_key;
    logic [PAYLOAD_BITS-1:0] r_res_pay, n_res_pay;
    logic                    r_res_empty, n_res_empty;

    logic                    r_out_valid, n_out_valid;
    logic                    r_out_ok;
    logic [KEY_W-1:0]        r_out_key;
    logic [PAYLOAD_BITS-1:0] r_out_pay;
    logic                    r_out_empty;
    logic                    out_load;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [WIDE_W-1:0]       in_pay_wide;
    logic [WIDE_W-1:0]       out_pay_wide;

    eoq_pkg::t_scan_ctl      scan_ctl;
    logic [IDX_W-1:0]        best_idx;
    logic [KEY_W-1:0]        best_key;
    logic [PAYLOAD_BITS-1:0] best_pay;

    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] best_next;
    logic             scan_last;

    assign rd_key      = ram_rdata[WORD_W-1 -: KEY_W];
    assign rd_pay      = ram_rdata[PAYLOAD_BITS-1:0];
    assign in_pay_wide = WIDE_W'(i_item_payload);

    assign idx_next  = CNT_W'(r_idx) + CNT_W'(1);
    assign best_next = CNT_W'(best_idx) + CNT_W'(1);
    assign scan_last = r_oldest || (idx_next == r_count);

    eoq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    eoq_scan #(
        .DEPTH (QUEUE_DEPTH),
        .PAY_W (PAYLOAD_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_ctl      (scan_ctl),
        .i_idx      (r_idx),
        .i_key      (rd_key),
        .i_pay      (rd_pay),
        .o_best_idx (best_idx),
        .o_best_key (best_key),
        .o_best_pay (best_pay)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_oldest    = r_oldest;
        n_res_ok    = r_res_ok;
        n_res_key   = r_res_key;
        n_res_pay   = r_res_pay;
        n_res_empty = r_res_empty;
        ram_we      = 1'b0;
        ram_waddr   = r_count[IDX_W-1:0];
        ram_wdata   = {i_expiry_key, in_pay_wide[PAYLOAD_BITS-1:0]};
        ram_raddr   = '0;
        scan_ctl    = '0;
        out_load    = 1'b0;
        o_in_ready  = 1'b0;

        case (r_state)
            eoq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_res_ok    = 1'b0;
                    n_res_key   = '0;
                    n_res_pay   = '0;
                    n_res_empty = (r_count == '0);
                    n_state     = eoq_pkg::ST_FIN;
                    case (eoq_pkg::t_cmd'(i_cmd))
                        eoq_pkg::CMD_PUSH: begin
                            if (r_count < CNT_W'(QUEUE_DEPTH)) begin
                                ram_we      = 1'b1;
                                n_count     = r_count + CNT_W'(1);
                                n_res_ok    = 1'b1;
                                n_res_empty = 1'b0;
                            end
                        end
                        eoq_pkg::CMD_POP_OLDEST, eoq_pkg::CMD_POP_EXPIRY: begin
                            if (r_count != '0) begin
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_oldest  = (eoq_pkg::t_cmd'(i_cmd) == eoq_pkg::CMD_POP_OLDEST);
                                n_state   = eoq_pkg::ST_SCAN;
                            end
                        end
                        eoq_pkg::CMD_CLEAR: begin
                            n_count     = '0;
                            n_res_ok    = 1'b1;
                            n_res_empty = 1'b1;
                        end
                        default: begin
                            n_state = eoq_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            eoq_pkg::ST_SCAN: begin
                scan_ctl.load = (r_idx == '0);
                scan_ctl.step = (r_idx != '0);
                if (!scan_last) begin
                    ram_raddr = idx_next[IDX_W-1:0];
                    n_idx     = idx_next[IDX_W-1:0];
                end else begin
                    n_res_ok    = 1'b1;
                    n_res_key   = best_key;
                    n_res_pay   = best_pay;
                    n_res_empty = (r_count == CNT_W'(1));
                    if (best_next < r_count) begin
                        // close the gap: fetch the entry behind the removed one
                        ram_raddr = best_next[IDX_W-1:0];
                        n_idx     = best_next[IDX_W-1:0];
                        n_state   = eoq_pkg::ST_SHIFT;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_state = eoq_pkg::ST_FIN;
                    end
                end
            end

            eoq_pkg::ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx - IDX_W'(1);
                ram_wdata = ram_rdata;
                if (idx_next < r_count) begin
                    ram_raddr = idx_next[IDX_W-1:0];
                    n_idx     = idx_next[IDX_W-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = eoq_pkg::ST_FIN;
                end
            end

            eoq_pkg::ST_FIN: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = eoq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = eoq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= eoq_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_oldest    <= n_oldest;
        r_res_ok    <= n_res_ok;
        r_res_key   <= n_res_key;
        r_res_pay   <= n_res_pay;
        r_res_empty <= n_res_empty;
        if (out_load) begin
            r_out_ok    <= r_res_ok;
            r_out_key   <= r_res_key;
            r_out_pay   <= r_res_pay;
            r_out_empty <= r_res_empty;
        end
    end

    assign out_pay_wide  = WIDE_W'(r_out_pay);
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_out_expiry  = r_out_key;
    assign o_out_payload = out_pay_wide[FLD_W-1:0];
    assign o_now_empty   = r_out_empty;

endmodule

`default_nettype wire
